FILE: src/mbom_pkg.sv
// ----------------------------------------------------------------------------
// Mux buffer overflow monitor package
// Shared types and constants: request and result records, the threshold
// record passed from the configuration logic and the reset thresholds.
// ----------------------------------------------------------------------------
package mbom_pkg;

   // Number of channel rates that are summed (1 to 8). The request always
   // carries eight high bytes; channels at or above this count are ignored.
   localparam int NUM_CHANNELS = 8;
   localparam int NUM_CH_FIELDS = 8;

   // Field widths.
   localparam int KBPS_W  = 18;
   localparam int PROD_W  = 25;   // kbps times 66
   localparam int UNIT_W  = 15;   // unit t = kbps * 66 / 1000
   localparam int HI_W    = 15;   // 3t/2
   localparam int LO_W    = 14;   // 8t/10
   localparam int SUM_W   = 19;
   localparam int RATE_W  = 17;
   localparam int COUNT_W = 16;
   localparam int CNT_W   = 4;

   // Reset value of the configured output bitrate and the thresholds that
   // follow from it.
   localparam int KBPS_RESET_INT = 60000;
   localparam int UNIT_RESET_INT = KBPS_RESET_INT * 66 / 1000;
   localparam logic [PROD_W-1:0] PROD_RESET = PROD_W'(KBPS_RESET_INT * 66);
   localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(UNIT_RESET_INT);
   localparam logic [HI_W-1:0]   HI_RESET   = HI_W'(UNIT_RESET_INT * 3 / 2);
   localparam logic [LO_W-1:0]   LO_RESET   = LO_W'(UNIT_RESET_INT * 8 / 10);

   // Reciprocals for the constant divisions. (kbps*66)/1000 is done as
   // ((kbps*66) >> 3) / 125, and 8t/10 as 4t/5; both are exact over the
   // full operand range with these shifts.
   localparam int RECIP_125_SHIFT = 29;
   localparam logic [22:0] RECIP_125 = 23'((2 ** RECIP_125_SHIFT + 124) / 125);
   localparam int RECIP_5_SHIFT = 19;
   localparam logic [16:0] RECIP_5 = 17'((2 ** RECIP_5_SHIFT + 4) / 5);

   // Output rate scale: count * 1504 >> 10.
   localparam logic [26:0] RATE_SCALE = 27'd1504;
   localparam int RATE_SHIFT = 10;

   // Hysteresis counter limits.
   localparam logic [CNT_W-1:0] COUNT_MAX        = 4'd10;
   localparam logic [CNT_W-1:0] SET_ABOVE        = 4'd7;
   localparam logic [CNT_W-1:0] CLEAR_ABOVE      = 4'd7;
   localparam logic [CNT_W-1:0] CLEAR_OVER_BELOW = 4'd3;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_NO_RATE  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [NUM_CH_FIELDS-1:0][7:0] rate_high;
      logic [7:0]                    rate_low;
      logic [COUNT_W-1:0]            packet_count;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic              overflow;
      logic [SUM_W-1:0]  total_rate;
      logic [RATE_W-1:0] out_rate;
   } rsp_type;

   typedef struct packed {
      logic            busy;   // thresholds are being recalculated
      logic [HI_W-1:0] hi;
      logic [LO_W-1:0] lo;
   } thr_type;

endpackage

FILE: src/mbom_thresh.sv
// ----------------------------------------------------------------------------
// Mux buffer overflow monitor threshold pipeline
// Turns a write of the output bitrate into the high and low thresholds over
// three registered steps and flags the recalculation as busy.
// ----------------------------------------------------------------------------
module mbom_thresh (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [mbom_pkg::KBPS_W-1:0]  csr_wr_data,
   output mbom_pkg::thr_type            thr
);

   logic [mbom_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [mbom_pkg::UNIT_W-1:0] unit_ff, unit_in;
   logic [mbom_pkg::HI_W-1:0]   hi_ff, hi_in;
   logic [mbom_pkg::LO_W-1:0]   lo_ff, lo_in;
   logic                        settle_ff;
   logic [44:0]                 div_prod;
   logic [16:0]                 three_t;
   logic [16:0]                 four_t;
   logic [33:0]                 lo_prod;

   // Step 1: times 66 as two shifted copies.
   assign prod_in = (mbom_pkg::PROD_W'(csr_wr_data) << 6)
                  + (mbom_pkg::PROD_W'(csr_wr_data) << 1);

   // Step 2: divide by 1000 as a divide by 8 and a reciprocal multiply by 125.
   assign div_prod = 45'(prod_ff[mbom_pkg::PROD_W-1:3]) * 45'(mbom_pkg::RECIP_125);
   assign unit_in  = div_prod[mbom_pkg::RECIP_125_SHIFT +: mbom_pkg::UNIT_W];

   // Step 3: 3t/2 by shift and add, 8t/10 as 4t/5 by reciprocal multiply.
   assign three_t = 17'({unit_ff, 1'b0}) + 17'(unit_ff);
   assign hi_in   = three_t[mbom_pkg::HI_W:1];
   assign four_t  = {unit_ff, 2'b00};
   assign lo_prod = 34'(four_t) * 34'(mbom_pkg::RECIP_5);
   assign lo_in   = lo_prod[mbom_pkg::RECIP_5_SHIFT +: mbom_pkg::LO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff   <= mbom_pkg::PROD_RESET;
         unit_ff   <= mbom_pkg::UNIT_RESET;
         hi_ff     <= mbom_pkg::HI_RESET;
         lo_ff     <= mbom_pkg::LO_RESET;
         settle_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            prod_ff <= prod_in;
         end
         unit_ff   <= unit_in;
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
         settle_ff <= csr_wr_en;
      end
   end

   // Busy in the write cycle and the one after it; the thresholds are final
   // before any request accepted later is evaluated.
   assign thr.busy = csr_wr_en | settle_ff;
   assign thr.hi   = hi_ff;
   assign thr.lo   = lo_ff;

endmodule

FILE: src/mbom_monitor.sv
// ----------------------------------------------------------------------------
// Mux buffer overflow monitor evaluation stage
// Sums the channel rates, scales the output packet count, and keeps the
// over and under counters and the overflow latch.
// ----------------------------------------------------------------------------
module mbom_monitor (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  mbom_pkg::req_type   req,
   input  mbom_pkg::thr_type   thr,
   output mbom_pkg::rsp_type   rsp
);

   logic [mbom_pkg::CNT_W-1:0]  over_ff, over_in;
   logic [mbom_pkg::CNT_W-1:0]  under_ff, under_in;
   logic                        latch_ff, latch_in;
   logic [mbom_pkg::SUM_W-1:0]  sum;
   logic [26:0]                 rate_prod;
   logic [mbom_pkg::RATE_W-1:0] rate;
   logic                        rate_zero;

   always_comb begin
      sum = '0;
      for (int c = 0; c < mbom_pkg::NUM_CHANNELS; c++) begin
         sum = sum + mbom_pkg::SUM_W'({req.rate_high[c], req.rate_low});
      end
   end

   assign rate_prod = 27'(req.packet_count) * mbom_pkg::RATE_SCALE;
   assign rate      = rate_prod[mbom_pkg::RATE_SHIFT +: mbom_pkg::RATE_W];
   assign rate_zero = (rate == '0);

   always_comb begin
      over_in  = over_ff;
      under_in = under_ff;
      latch_in = latch_ff;
      if (!rate_zero) begin
         if (sum >= mbom_pkg::SUM_W'(thr.hi)) begin
            if (over_ff < mbom_pkg::COUNT_MAX) begin
               over_in = over_ff + mbom_pkg::CNT_W'(1);
            end
            under_in = '0;
         end else if (sum < mbom_pkg::SUM_W'(thr.lo)) begin
            if (under_ff < mbom_pkg::COUNT_MAX) begin
               under_in = under_ff + mbom_pkg::CNT_W'(1);
            end
            over_in = '0;
         end else begin
            over_in  = '0;
            under_in = '0;
         end
         if (over_in > mbom_pkg::SET_ABOVE) begin
            latch_in = 1'b1;
         end else if (under_in > mbom_pkg::CLEAR_ABOVE &&
                      over_in < mbom_pkg::CLEAR_OVER_BELOW) begin
            latch_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         over_ff  <= '0;
         under_ff <= '0;
         latch_ff <= 1'b0;
      end else if (advance) begin
         over_ff  <= over_in;
         under_ff <= under_in;
         latch_ff <= latch_in;
      end
   end

   always_comb begin
      if (rate_zero) begin
         rsp.status = mbom_pkg::STATUS_NO_RATE;
      end else if (latch_in) begin
         rsp.status = mbom_pkg::STATUS_OVERFLOW;
      end else begin
         rsp.status = mbom_pkg::STATUS_NONE;
      end
      rsp.overflow   = latch_in;
      rsp.total_rate = sum;
      rsp.out_rate   = rate;
   end

endmodule

FILE: src/mux_buffer_overflow_monitor.sv
// ----------------------------------------------------------------------------
// Mux buffer overflow monitor
// Watches the summed channel input rate against thresholds derived from the
// configured output bitrate and reports a latched buffer overflow status.
// ----------------------------------------------------------------------------
// The block takes one request per clock and presents one response for each
// while no response stall or threshold recalculation holds it: the
// request is captured in an input register, evaluated by one pass of short
// logic (an eight-way add, two compares, the counter update and a constant
// multiply), and the response lands in an output register. A stalled
// response holds the pipeline, but an empty input register still takes a
// request while the finished response waits. Writing the output bitrate
// starts a three-step threshold recalculation (multiply by 66, divide by
// 1000, then form 3t/2 and 8t/10); requests are stalled in the write cycle
// and in the cycle after it, and thresholds are ready for everything
// accepted later. The thresholds reset to those of 60000 kbps. A request
// whose packet count is zero reports the no-bitrate status and leaves the
// counters and the overflow latch untouched.
module mux_buffer_overflow_monitor (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_ch0_rate_high,
   input  logic [7:0]                        req_ch1_rate_high,
   input  logic [7:0]                        req_ch2_rate_high,
   input  logic [7:0]                        req_ch3_rate_high,
   input  logic [7:0]                        req_ch4_rate_high,
   input  logic [7:0]                        req_ch5_rate_high,
   input  logic [7:0]                        req_ch6_rate_high,
   input  logic [7:0]                        req_ch7_rate_high,
   input  logic [7:0]                        req_shared_rate_low,
   input  logic [mbom_pkg::COUNT_W-1:0]      req_out_packet_count,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status_code,
   output logic                              rsp_overflow,
   output logic [mbom_pkg::SUM_W-1:0]        rsp_total_input_rate,
   output logic [mbom_pkg::RATE_W-1:0]       rsp_out_rate_kbps,
   // Output bitrate register.
   input  logic                              csr_wr_en,
   input  logic [mbom_pkg::KBPS_W-1:0]       csr_wr_data
);

   mbom_pkg::thr_type thr;
   mbom_pkg::req_type req_in;
   mbom_pkg::req_type s1_req_ff;
   mbom_pkg::rsp_type result;
   mbom_pkg::rsp_type rsp_ff;

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready;
   logic advance;
   logic s1_free;
   logic accept;

   mbom_thresh u_thresh (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .thr         (thr)
   );

   // Gather the request fields into one record.
   assign req_in.rate_high[0]  = req_ch0_rate_high;
   assign req_in.rate_high[1]  = req_ch1_rate_high;
   assign req_in.rate_high[2]  = req_ch2_rate_high;
   assign req_in.rate_high[3]  = req_ch3_rate_high;
   assign req_in.rate_high[4]  = req_ch4_rate_high;
   assign req_in.rate_high[5]  = req_ch5_rate_high;
   assign req_in.rate_high[6]  = req_ch6_rate_high;
   assign req_in.rate_high[7]  = req_ch7_rate_high;
   assign req_in.rate_low      = req_shared_rate_low;
   assign req_in.packet_count  = req_out_packet_count;

   // The output register frees when it is empty or its response is taken.
   // The held request moves on then; unless thresholds are busy, the input
   // register takes a new request if empty or as its current one leaves.
   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign advance      = s1_valid_ff && out_ready;
   assign s1_free      = !s1_valid_ff || advance;
   assign req_stall    = !s1_free || thr.busy;
   assign accept       = req_valid && !req_stall;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   // The counters and the latch advance exactly once per request, in the
   // cycle its response is written into the output register.
   mbom_monitor u_monitor (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (s1_req_ff),
      .thr     (thr),
      .rsp     (result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status_code      = rsp_ff.status;
   assign rsp_overflow         = rsp_ff.overflow;
   assign rsp_total_input_rate = rsp_ff.total_rate;
   assign rsp_out_rate_kbps    = rsp_ff.out_rate;

   // No request is taken in the cycle after a bitrate write.
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !(req_valid && !req_stall))
      else $error("request accepted while thresholds were recalculating");

   // The no-bitrate status goes with a zero output rate and only with it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status_code == mbom_pkg::STATUS_NO_RATE) ==
                     (rsp_out_rate_kbps == '0)))
      else $error("no-bitrate status disagrees with the output rate");

   // With a nonzero output rate the status reflects the overflow latch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code != mbom_pkg::STATUS_NO_RATE |->
         (rsp_overflow == (rsp_status_code == mbom_pkg::STATUS_OVERFLOW)))
      else $error("status code disagrees with the overflow latch");

   // A held request stays in the input register until it moves on.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("held request lost from the input register");

endmodule
